/* hdl/cylinder_wind_field_force_top_defines.svh */
// ----------------------------------------------------------------------------
// cylinder wind field force - assertion macros
// concurrent check helpers, empty when synthesised
// ----------------------------------------------------------------------------
`ifndef CYLINDER_WIND_FIELD_FORCE_TOP_DEFINES_SVH
`define CYLINDER_WIND_FIELD_FORCE_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define CWF_ASSERT_IMP(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("cwf check failed");
`define CWF_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("cwf check failed");
`else
`define CWF_ASSERT_IMP(name, clk, rst, ante, cons)
`define CWF_ASSERT_NEXT(name, clk, rst, ante, cons)
`endif
`endif

/* hdl/cwf_pkg.sv */
// ----------------------------------------------------------------------------
// cwf_pkg
// widths, register codes and helpers for the cylinder wind force block
// ----------------------------------------------------------------------------
package cwf_pkg;

   localparam int unsigned POS_W       = 16;
   localparam int unsigned FORCE_W     = 18;
   localparam int unsigned STRENGTH_W  = 18;
   localparam int unsigned SIZE_W      = 16;
   localparam int unsigned FALL_W      = 9;
   localparam int unsigned CSR_INDEX_W = 3;
   localparam int unsigned CSR_DATA_W  = 18;

   localparam logic [STRENGTH_W-1:0] STRENGTH_RST = 18'd0;
   localparam logic [SIZE_W-1:0]     LENGTH_RST   = 16'd1280;
   localparam logic [SIZE_W-1:0]     RADIUS_RST   = 16'd256;
   localparam logic [SIZE_W-1:0]     SIZE_MIN     = 16'd26;
   localparam logic [FALL_W-1:0]     FALL_ONE     = 9'd256;

   localparam int unsigned FADE_W   = 17;
   localparam logic [FADE_W-1:0] FADE_ONE = 17'h10000;
   localparam int unsigned FNUM_W   = 40;
   localparam int unsigned DEN_W    = 24;
   localparam int unsigned SQ_W     = 40;
   localparam int unsigned ROOT_W   = 20;
   localparam int unsigned S16_W    = 26;
   localparam int unsigned VNUM_W   = 46;
   localparam int unsigned VDEN_W   = 28;
   localparam int unsigned VQ_W     = 19;

   localparam logic [VQ_W-1:0] MAG_POS_MAX = 19'd131071;
   localparam logic [VQ_W-1:0] MAG_NEG_MAX = 19'd131072;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_STRENGTH = 3'd0,
      CSR_LENGTH   = 3'd1,
      CSR_RADIUS   = 3'd2,
      CSR_RFALL    = 3'd3,
      CSR_FFALL    = 3'd4,
      CSR_BFALL    = 3'd5,
      CSR_VORTEX   = 3'd6
   } csr_index_type;

   function automatic logic [FADE_W-1:0] fade_sel(input logic zero, input logic one,
                                                  input logic [FADE_W-1:0] quo);
      logic [FADE_W-1:0] res;
      if (zero) begin
         res = '0;
      end else if (one || (quo > FADE_ONE)) begin
         res = FADE_ONE;
      end else begin
         res = quo;
      end
      return res;
   endfunction

   function automatic logic [FORCE_W-1:0] sat_force(input logic [VQ_W-1:0] mag,
                                                    input logic neg);
      logic [VQ_W-1:0]    negm;
      logic [FORCE_W-1:0] res;
      negm = ~mag + 1'b1;
      if (neg) begin
         res = (mag > MAG_NEG_MAX) ? 18'h20000 : negm[FORCE_W-1:0];
      end else begin
         res = (mag > MAG_POS_MAX) ? 18'h1FFFF : mag[FORCE_W-1:0];
      end
      return res;
   endfunction

endpackage

/* hdl/cwf_delay.sv */
// ----------------------------------------------------------------------------
// cwf_delay
// stallable delay line that keeps side data level with the pipeline
// ----------------------------------------------------------------------------
module cwf_delay #(
   parameter int unsigned WIDTH = 1,
   parameter int unsigned DEPTH = 1
) (
   input  logic             clock,
   input  logic             en,
   input  logic [WIDTH-1:0] din,
   output logic [WIDTH-1:0] dout
);

   logic [WIDTH-1:0] tap_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (en) begin
         tap_ff[0] <= din;
         for (int i = 1; i < DEPTH; i++) begin
            tap_ff[i] <= tap_ff[i-1];
         end
      end
   end

   assign dout = tap_ff[DEPTH-1];

endmodule

/* hdl/cwf_isqrt.sv */
// ----------------------------------------------------------------------------
// cwf_isqrt
// pipelined integer square root, one root bit per stage
// ----------------------------------------------------------------------------
module cwf_isqrt #(
   parameter int unsigned IN_W   = 40,
   parameter int unsigned ROOT_W = 20
) (
   input  logic              clock,
   input  logic              en,
   input  logic [IN_W-1:0]   radicand,
   output logic [ROOT_W-1:0] root
);

   logic [IN_W-1:0]   rem_ff  [ROOT_W];
   logic [ROOT_W-1:0] root_ff [ROOT_W];

   for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
      localparam int unsigned BITPOS = ROOT_W - 1 - k;
      logic [IN_W-1:0]   rem_prev;
      logic [ROOT_W-1:0] root_prev;
      logic [IN_W-1:0]   trial;

      if (k == 0) begin : g_first
         assign rem_prev  = radicand;
         assign root_prev = '0;
      end else begin : g_next
         assign rem_prev  = rem_ff[k-1];
         assign root_prev = root_ff[k-1];
      end

      assign trial = ({{(IN_W-ROOT_W){1'b0}}, root_prev} << (BITPOS + 1))
                   + ({{(IN_W-1){1'b0}}, 1'b1} << (2 * BITPOS));

      always_ff @(posedge clock) begin
         if (en) begin
            if (rem_prev >= trial) begin
               rem_ff[k]  <= rem_prev - trial;
               root_ff[k] <= root_prev | ({{(ROOT_W-1){1'b0}}, 1'b1} << BITPOS);
            end else begin
               rem_ff[k]  <= rem_prev;
               root_ff[k] <= root_prev;
            end
         end
      end
   end

   assign root = root_ff[ROOT_W-1];

endmodule

/* hdl/cwf_div.sv */
// ----------------------------------------------------------------------------
// cwf_div
// pipelined restoring divider, one quotient bit per stage
// ----------------------------------------------------------------------------
module cwf_div #(
   parameter int unsigned NUM_W = 40,
   parameter int unsigned DEN_W = 24,
   parameter int unsigned QUO_W = 17
) (
   input  logic             clock,
   input  logic             en,
   input  logic [NUM_W-1:0] numer,
   input  logic [DEN_W-1:0] denom,
   output logic [QUO_W-1:0] quo
);

   localparam int unsigned REM_W = (NUM_W + 1 > DEN_W + QUO_W) ? NUM_W + 1 : DEN_W + QUO_W;

   logic [REM_W-1:0] rem_ff [QUO_W];
   logic [DEN_W-1:0] den_ff [QUO_W];
   logic [QUO_W-1:0] quo_ff [QUO_W];

   for (genvar k = 0; k < QUO_W; k++) begin : g_stage
      localparam int unsigned BITPOS = QUO_W - 1 - k;
      logic [REM_W-1:0] rem_prev;
      logic [DEN_W-1:0] den_prev;
      logic [QUO_W-1:0] quo_prev;
      logic [REM_W-1:0] shifted;

      if (k == 0) begin : g_first
         assign rem_prev = {{(REM_W-NUM_W){1'b0}}, numer};
         assign den_prev = denom;
         assign quo_prev = '0;
      end else begin : g_next
         assign rem_prev = rem_ff[k-1];
         assign den_prev = den_ff[k-1];
         assign quo_prev = quo_ff[k-1];
      end

      assign shifted = {{(REM_W-DEN_W){1'b0}}, den_prev} << BITPOS;

      always_ff @(posedge clock) begin
         if (en) begin
            den_ff[k] <= den_prev;
            if (rem_prev >= shifted) begin
               rem_ff[k] <= rem_prev - shifted;
               quo_ff[k] <= quo_prev | ({{(QUO_W-1){1'b0}}, 1'b1} << BITPOS);
            end else begin
               rem_ff[k] <= rem_prev;
               quo_ff[k] <= quo_prev;
            end
         end
      end
   end

   assign quo = quo_ff[QUO_W-1];

endmodule

/* hdl/cylinder_wind_field_force_top.sv */
// ----------------------------------------------------------------------------
// cylinder_wind_field_force_top
// wind force inside a cylindrical volume from a local position
//
//   channel | direction | handshake             | payload
//   req     | in        | req_tvalid/req_tready | pos_x, pos_y, pos_z
//   rsp     | out       | rsp_tvalid/rsp_tready | force_x, force_y, force_z
//   csr     | in        | csr_valid/csr_ready   | csr_index, csr_data
//
// one request per cycle sustained while the output buffer is not full
// latency set by the square root and two dividers in series, one bit a stage
// reset is synchronous and clears registers to defaults and empties the pipe
// a two entry output buffer lets requests flow while a response waits
// the pipeline holds as a whole only when that buffer is full
// ----------------------------------------------------------------------------
`include "cylinder_wind_field_force_top_defines.svh"

module cylinder_wind_field_force_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,   // pos_x [15:0], pos_y [31:16], pos_z [47:32]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [55:0] rsp_tdata,   // force_x [17:0], force_y [35:18], force_z [53:36]
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [cwf_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [cwf_pkg::CSR_DATA_W-1:0]  csr_data
);

   localparam int unsigned T_A     = 1;
   localparam int unsigned T_FADE  = T_A + cwf_pkg::FADE_W;
   localparam int unsigned T_FMIN  = T_FADE + 1;
   localparam int unsigned T_C     = 3;
   localparam int unsigned T_ROOT  = T_C + cwf_pkg::ROOT_W;
   localparam int unsigned T_D     = T_ROOT + 1;
   localparam int unsigned T_RAD   = T_D + cwf_pkg::FADE_W;
   localparam int unsigned T_G     = T_RAD + 3;
   localparam int unsigned T_H     = T_G + 1;
   localparam int unsigned T_VORT  = T_H + cwf_pkg::VQ_W;
   localparam int unsigned T_OUT   = T_VORT + 1;
   localparam int unsigned OUT_W   = 3 * cwf_pkg::FORCE_W;

   // registers
   logic [cwf_pkg::STRENGTH_W-1:0] strength_ff;
   logic [cwf_pkg::SIZE_W-1:0]     length_ff;
   logic [cwf_pkg::SIZE_W-1:0]     radius_ff;
   logic [cwf_pkg::FALL_W-1:0]     rfall_ff;
   logic [cwf_pkg::FALL_W-1:0]     ffall_ff;
   logic [cwf_pkg::FALL_W-1:0]     bfall_ff;
   logic                           vortex_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         strength_ff <= cwf_pkg::STRENGTH_RST;
         length_ff   <= cwf_pkg::LENGTH_RST;
         radius_ff   <= cwf_pkg::RADIUS_RST;
         rfall_ff    <= '0;
         ffall_ff    <= '0;
         bfall_ff    <= '0;
         vortex_ff   <= 1'b0;
      end else if (csr_valid) begin
         unique case (cwf_pkg::csr_index_type'(csr_index))
            cwf_pkg::CSR_STRENGTH: strength_ff <= csr_data;
            cwf_pkg::CSR_LENGTH:   length_ff   <= csr_data[cwf_pkg::SIZE_W-1:0];
            cwf_pkg::CSR_RADIUS:   radius_ff   <= csr_data[cwf_pkg::SIZE_W-1:0];
            cwf_pkg::CSR_RFALL:    rfall_ff    <= csr_data[cwf_pkg::FALL_W-1:0];
            cwf_pkg::CSR_FFALL:    ffall_ff    <= csr_data[cwf_pkg::FALL_W-1:0];
            cwf_pkg::CSR_BFALL:    bfall_ff    <= csr_data[cwf_pkg::FALL_W-1:0];
            cwf_pkg::CSR_VORTEX:   vortex_ff   <= csr_data[0];
            default: ;
         endcase
      end
   end

   assign csr_ready = 1'b1;

   // clamped settings and fade denominators
   logic [15:0] len_w, rad_w;
   logic [8:0]  rf_w, pf_w, nfc_w, prest_w, nf_w;
   logic [24:0] den_p_full, den_n_full, den_r_full;
   logic [23:0] den_p_w, den_n_w, den_r_w;
   logic        w_neg;
   logic [17:0] aw_w;

   assign len_w   = (length_ff < cwf_pkg::SIZE_MIN) ? cwf_pkg::SIZE_MIN : length_ff;
   assign rad_w   = (radius_ff < cwf_pkg::SIZE_MIN) ? cwf_pkg::SIZE_MIN : radius_ff;
   assign rf_w    = (rfall_ff > cwf_pkg::FALL_ONE) ? cwf_pkg::FALL_ONE : rfall_ff;
   assign pf_w    = (ffall_ff > cwf_pkg::FALL_ONE) ? cwf_pkg::FALL_ONE : ffall_ff;
   assign nfc_w   = (bfall_ff > cwf_pkg::FALL_ONE) ? cwf_pkg::FALL_ONE : bfall_ff;
   assign prest_w = cwf_pkg::FALL_ONE - pf_w;
   assign nf_w    = (nfc_w > prest_w) ? prest_w : nfc_w;

   assign den_p_full = {9'd0, len_w} * {16'd0, pf_w};
   assign den_n_full = {9'd0, len_w} * {16'd0, nf_w};
   assign den_r_full = {9'd0, rad_w} * {16'd0, rf_w};
   assign den_p_w    = den_p_full[23:0];
   assign den_n_w    = den_n_full[23:0];
   assign den_r_w    = den_r_full[23:0];

   assign w_neg = strength_ff[17];
   assign aw_w  = w_neg ? (~strength_ff + 1'b1) : strength_ff;

   // flow control
   logic [1:0]       cnt_ff;
   logic             en_w;
   logic [T_OUT-1:0] valid_ff;

   assign en_w       = (cnt_ff != 2'd2);
   assign req_tready = en_w;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en_w) begin
         valid_ff <= {valid_ff[T_OUT-2:0], req_tvalid};
      end
   end

   // stage a: magnitudes and end numerators
   logic signed [15:0] px_w, py_w, pz_w;
   logic signed [17:0] x2_w, lens_w;
   logic signed [17:0] np_ff, nn_ff;
   logic [15:0]        ay_ff, az_ff;
   logic [1:0]         sign_w, sign_d;

   assign px_w   = req_tdata[15:0];
   assign py_w   = req_tdata[31:16];
   assign pz_w   = req_tdata[47:32];
   assign x2_w   = {px_w[15], px_w, 1'b0};
   assign lens_w = {2'b00, len_w};
   assign sign_w = {(!pz_w[15]) && (pz_w != '0), py_w[15]};

   always_ff @(posedge clock) begin
      if (en_w) begin
         np_ff <= lens_w - x2_w;
         nn_ff <= lens_w + x2_w;
         ay_ff <= py_w[15] ? (~py_w + 1'b1) : py_w;
         az_ff <= pz_w[15] ? (~pz_w + 1'b1) : pz_w;
      end
   end

   cwf_delay #(.WIDTH(2), .DEPTH(T_VORT)) u_sign_dly (
      .clock(clock), .en(en_w), .din(sign_w), .dout(sign_d));

   logic [31:0] abs_d;
   cwf_delay #(.WIDTH(32), .DEPTH(T_G - T_A)) u_abs_dly (
      .clock(clock), .en(en_w), .din({ay_ff, az_ff}), .dout(abs_d));

   // end fades
   logic [3:0]  eflag_w, eflag_d;
   logic [16:0] qp_w, qn_w;
   logic [16:0] fmin_ff, fmin_d;
   logic [16:0] fp_w, fn_w;

   assign eflag_w = {np_ff[17] || (np_ff == '0),
                     {np_ff[16:0], 7'd0} >= den_p_w,
                     nn_ff[17] || (nn_ff == '0),
                     {nn_ff[16:0], 7'd0} >= den_n_w};

   cwf_div #(.NUM_W(cwf_pkg::FNUM_W), .DEN_W(cwf_pkg::DEN_W), .QUO_W(cwf_pkg::FADE_W))
      u_div_p (.clock(clock), .en(en_w), .numer({np_ff[16:0], 23'd0}),
               .denom(den_p_w), .quo(qp_w));

   cwf_div #(.NUM_W(cwf_pkg::FNUM_W), .DEN_W(cwf_pkg::DEN_W), .QUO_W(cwf_pkg::FADE_W))
      u_div_n (.clock(clock), .en(en_w), .numer({nn_ff[16:0], 23'd0}),
               .denom(den_n_w), .quo(qn_w));

   cwf_delay #(.WIDTH(4), .DEPTH(cwf_pkg::FADE_W)) u_eflag_dly (
      .clock(clock), .en(en_w), .din(eflag_w), .dout(eflag_d));

   assign fp_w = cwf_pkg::fade_sel(eflag_d[3], eflag_d[2], qp_w);
   assign fn_w = cwf_pkg::fade_sel(eflag_d[1], eflag_d[0], qn_w);

   always_ff @(posedge clock) begin
      if (en_w) begin
         fmin_ff <= (fp_w < fn_w) ? fp_w : fn_w;
      end
   end

   cwf_delay #(.WIDTH(17), .DEPTH(T_RAD - T_FMIN)) u_fmin_dly (
      .clock(clock), .en(en_w), .din(fmin_ff), .dout(fmin_d));

   // stages b and c: squared radius
   logic [31:0] ysq_ff, zsq_ff;
   logic [32:0] sqsum_w;
   logic [cwf_pkg::SQ_W-1:0] sq_ff;
   logic [cwf_pkg::ROOT_W-1:0] r12_w;

   assign sqsum_w = {1'b0, ysq_ff} + {1'b0, zsq_ff};

   always_ff @(posedge clock) begin
      if (en_w) begin
         ysq_ff <= {16'd0, ay_ff} * {16'd0, ay_ff};
         zsq_ff <= {16'd0, az_ff} * {16'd0, az_ff};
         sq_ff  <= {sqsum_w[31:0], 8'd0};
      end
   end

   cwf_isqrt #(.IN_W(cwf_pkg::SQ_W), .ROOT_W(cwf_pkg::ROOT_W)) u_isqrt (
      .clock(clock), .en(en_w), .radicand(sq_ff), .root(r12_w));

   // stage d: radial fade
   logic signed [20:0] rn_ff;
   logic [19:0]        r12_ff, r12_d;
   logic [1:0]         rflag_w, rflag_d;
   logic [16:0]        qr_w, fr_w;

   always_ff @(posedge clock) begin
      if (en_w) begin
         rn_ff  <= {1'b0, rad_w, 4'd0} - {1'b0, r12_w};
         r12_ff <= r12_w;
      end
   end

   assign rflag_w = {rn_ff[20] || (rn_ff == '0), {rn_ff[19:0], 4'd0} >= den_r_w};

   cwf_div #(.NUM_W(cwf_pkg::FNUM_W), .DEN_W(cwf_pkg::DEN_W), .QUO_W(cwf_pkg::FADE_W))
      u_div_r (.clock(clock), .en(en_w), .numer({rn_ff[19:0], 20'd0}),
               .denom(den_r_w), .quo(qr_w));

   cwf_delay #(.WIDTH(2), .DEPTH(cwf_pkg::FADE_W)) u_rflag_dly (
      .clock(clock), .en(en_w), .din(rflag_w), .dout(rflag_d));

   cwf_delay #(.WIDTH(20), .DEPTH(T_G - T_D)) u_root_dly (
      .clock(clock), .en(en_w), .din(r12_ff), .dout(r12_d));

   assign fr_w = cwf_pkg::fade_sel(rflag_d[1], rflag_d[0], qr_w);

   // stages e to g: strength
   logic [33:0] f32_full;
   logic [32:0] f32_ff;
   logic [50:0] prod_full;
   logic [49:0] prod_ff;
   logic [50:0] rnd_w;
   logic [cwf_pkg::S16_W-1:0] s16_ff;

   assign f32_full  = {17'd0, fmin_d} * {17'd0, fr_w};
   assign prod_full = {18'd0, f32_ff} * {33'd0, aw_w};
   assign rnd_w     = {1'b0, prod_ff} + (51'd1 << 23);

   always_ff @(posedge clock) begin
      if (en_w) begin
         f32_ff  <= f32_full[32:0];
         prod_ff <= prod_full[49:0];
         s16_ff  <= rnd_w[49:24];
      end
   end

   // stage h: vortex numerators
   logic [45:0] ny_ff, nz_ff, ny_w, nz_w, half_w;
   logic [27:0] d_ff;
   logic [26:0] magx_sum_w;
   logic [19:0] side_w, side_d;
   logic [cwf_pkg::VQ_W-1:0] my_w, mz_w;

   assign half_w = {19'd0, r12_d, 7'd0};
   assign ny_w   = ({26'd0, abs_d[15:0], 4'd0} * {20'd0, s16_ff}) + half_w;
   assign nz_w   = ({26'd0, abs_d[31:16], 4'd0} * {20'd0, s16_ff}) + half_w;
   assign magx_sum_w = {1'b0, s16_ff} + 27'd128;
   assign side_w = {r12_d == '0, magx_sum_w[26:8]};

   always_ff @(posedge clock) begin
      if (en_w) begin
         ny_ff <= ny_w;
         nz_ff <= nz_w;
         d_ff  <= {r12_d, 8'd0};
      end
   end

   cwf_delay #(.WIDTH(20), .DEPTH(T_VORT - T_G)) u_side_dly (
      .clock(clock), .en(en_w), .din(side_w), .dout(side_d));

   cwf_div #(.NUM_W(cwf_pkg::VNUM_W), .DEN_W(cwf_pkg::VDEN_W), .QUO_W(cwf_pkg::VQ_W))
      u_div_y (.clock(clock), .en(en_w), .numer(ny_ff), .denom(d_ff), .quo(my_w));

   cwf_div #(.NUM_W(cwf_pkg::VNUM_W), .DEN_W(cwf_pkg::VDEN_W), .QUO_W(cwf_pkg::VQ_W))
      u_div_z (.clock(clock), .en(en_w), .numer(nz_ff), .denom(d_ff), .quo(mz_w));

   // output stage
   logic [OUT_W-1:0] force_ff;
   logic [17:0]      fx_w, fy_w, fz_w;

   assign fx_w = vortex_ff ? '0 : cwf_pkg::sat_force(side_d[18:0], w_neg);
   assign fy_w = (vortex_ff && !side_d[19]) ?
                 cwf_pkg::sat_force(my_w, sign_d[1] ^ w_neg) : '0;
   assign fz_w = (vortex_ff && !side_d[19]) ?
                 cwf_pkg::sat_force(mz_w, sign_d[0] ^ w_neg) : '0;

   always_ff @(posedge clock) begin
      if (en_w) begin
         force_ff <= {fz_w, fy_w, fx_w};
      end
   end

   // output buffer
   logic [OUT_W-1:0] buf_ff [2];
   logic             wr_ptr_ff, rd_ptr_ff;
   logic             push_w, pop_w;

   assign push_w = en_w && valid_ff[T_OUT-1];
   assign pop_w  = rsp_tvalid && rsp_tready;

   always_ff @(posedge clock) begin
      if (push_w) begin
         buf_ff[wr_ptr_ff] <= force_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         if (push_w) begin
            wr_ptr_ff <= ~wr_ptr_ff;
         end
         if (pop_w) begin
            rd_ptr_ff <= ~rd_ptr_ff;
         end
         cnt_ff <= cnt_ff + {1'b0, push_w} - {1'b0, pop_w};
      end
   end

   assign rsp_tvalid = (cnt_ff != 2'd0);
   assign rsp_tdata  = {2'b00, buf_ff[rd_ptr_ff]};

   `CWF_ASSERT_IMP(a_cnt_range, clock, reset, 1'b1, cnt_ff != 2'd3)
   `CWF_ASSERT_NEXT(a_full_hold, clock, reset, (cnt_ff == 2'd2) && !rsp_tready, cnt_ff == 2'd2)
   `CWF_ASSERT_NEXT(a_stall_hold, clock, reset, !en_w, $stable(valid_ff))
   `CWF_ASSERT_NEXT(a_push_count, clock, reset, push_w && !pop_w && (cnt_ff == 2'd0), cnt_ff == 2'd1)

endmodule
